// ===== rtl/core/fbu_pkg.sv =====
package fbu_pkg;

    localparam int BYTE_W          = 8;
    localparam int REG_W           = 13;
    localparam int BUF_W           = 32;
    localparam int HELD_W          = 6;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int COORD_BITS_DEF  = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Bits taken by a full pixel: flag plus three color bytes
    localparam logic [HELD_W-1:0] FULL_PIXEL_BITS = HELD_W'(25);
    localparam logic [HELD_W-1:0] FILL_PIXEL_BITS = HELD_W'(1);
    localparam logic [HELD_W-1:0] BYTE_BITS       = HELD_W'(8);

    localparam logic [BYTE_W-1:0] FILL_RED   = 8'hFF;
    localparam logic [BYTE_W-1:0] FILL_GREEN = 8'h00;
    localparam logic [BYTE_W-1:0] FILL_BLUE  = 8'hFF;

    // Register index, taken from the word address
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } queue_head_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              end_of_row;
        logic              last_of_image;
    } pixel_t;

    // True when the held bits start a pixel that is already complete
    function automatic logic pixel_ready(input logic [BUF_W-1:0] bits,
                                         input logic [HELD_W-1:0] held);
        logic [HELD_W-1:0] top;
        top = held - HELD_W'(1);
        return (held != '0) && (bits[top[4:0]] || (held >= FULL_PIXEL_BITS));
    endfunction

endpackage

// ===== rtl/core/fbu_in_queue.sv =====
module fbu_in_queue #(
    parameter int QUEUE_DEPTH = fbu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fbu_pkg::BYTE_W-1:0] data_byte,
    output fbu_pkg::queue_head_t       head,
    input  logic                       pop
);
    import fbu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [BYTE_W-1:0] store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              do_pop;

    assign in_stall   = (count_reg == FULL_CNT);
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.data  = store_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= data_byte;
        end
    end

endmodule

// ===== rtl/core/fbu_pixel_engine.sv =====
module fbu_pixel_engine #(
    parameter int COORD_BITS = fbu_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  fbu_pkg::queue_head_t      head,
    output logic                      pop,
    input  logic [fbu_pkg::REG_W-1:0] image_width,
    input  logic [fbu_pkg::REG_W-1:0] image_height,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fbu_pkg::pixel_t           pixel
);
    import fbu_pkg::*;

    localparam int CW = (COORD_BITS + 1 > REG_W) ? COORD_BITS + 1 : REG_W;
    localparam logic [CW-1:0] MAX_SIZE = CW'({1'b1, {COORD_BITS{1'b0}}});

    logic [BUF_W-1:0]      buf_reg, buf_next;
    logic [HELD_W-1:0]     held_reg, held_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [2:0]            npix_reg, npix_next;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    pixel_t                pixel_reg, pixel_next;

    logic [CW-1:0]         width_eff;
    logic [CW-1:0]         height_eff;
    logic [BUF_W-1:0]      merged;
    logic [HELD_W-1:0]     merged_held;
    logic [HELD_W-1:0]     top_idx;
    logic [HELD_W-1:0]     color_shift;
    logic [BUF_W-1:0]      shifted;
    logic [HELD_W-1:0]     held_after;
    logic                  flag;
    logic                  can_emit;
    logic                  eor;
    logic                  last;

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

    // Clamp the sizes into 1 .. 2^COORD_BITS
    always_comb
    begin
        width_eff  = CW'(image_width);
        height_eff = CW'(image_height);
        if (width_eff == '0)
        begin
            width_eff = CW'(1);
        end
        else if (width_eff > MAX_SIZE)
        begin
            width_eff = MAX_SIZE;
        end
        if (height_eff == '0)
        begin
            height_eff = CW'(1);
        end
        else if (height_eff > MAX_SIZE)
        begin
            height_eff = MAX_SIZE;
        end
    end

    // Pick the next pixel off the top of the bit buffer
    assign merged      = {buf_reg[BUF_W-BYTE_W-1:0], head.data};
    assign merged_held = held_reg + BYTE_BITS;
    assign pop         = !busy_reg && head.valid;
    assign top_idx     = held_reg - HELD_W'(1);
    assign flag        = buf_reg[top_idx[4:0]];
    assign color_shift = held_reg - FULL_PIXEL_BITS;
    assign shifted     = buf_reg >> color_shift[2:0];
    assign held_after  = flag ? held_reg - FILL_PIXEL_BITS : held_reg - FULL_PIXEL_BITS;
    assign can_emit    = busy_reg && (!out_valid_reg || !out_stall);
    assign eor         = (CW'(col_reg) + CW'(1)) >= width_eff;
    assign last        = eor && ((CW'(row_reg) + CW'(1)) >= height_eff);

    always_comb
    begin
        buf_next       = buf_reg;
        held_next      = held_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        npix_next      = npix_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        pixel_next     = pixel_reg;

        // Drop the output item once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            // Load the next byte behind the unread bits
            buf_next  = merged;
            held_next = merged_held;
            npix_next = '0;
            busy_next = pixel_ready(merged, merged_held);
        end
        else if (can_emit)
        begin
            out_valid_next           = 1'b1;
            pixel_next.end_of_row    = eor;
            pixel_next.last_of_image = last;
            if (flag)
            begin
                pixel_next.red   = FILL_RED;
                pixel_next.green = FILL_GREEN;
                pixel_next.blue  = FILL_BLUE;
            end
            else
            begin
                pixel_next.red   = shifted[23:16];
                pixel_next.green = shifted[15:8];
                pixel_next.blue  = shifted[7:0];
            end
            npix_next = npix_reg + 3'd1;
            if (last)
            begin
                // End of image: discard leftover bits and restart counters
                buf_next  = '0;
                held_next = '0;
                col_next  = '0;
                row_next  = '0;
                busy_next = 1'b0;
            end
            else
            begin
                held_next = held_after;
                if (eor)
                begin
                    col_next = '0;
                    row_next = row_reg + COORD_BITS'(1);
                end
                else
                begin
                    col_next = col_reg + COORD_BITS'(1);
                end
                busy_next = (npix_reg != 3'd7) && pixel_ready(buf_reg, held_after);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            npix_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            held_reg      <= held_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            npix_reg      <= npix_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

endmodule

// ===== rtl/core/flagged_rgb_bitstream_unpacker_core.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_stall   data_byte
// output    out_valid / out_stall red, green, blue, end_of_row, last_of_image
// config    APB psel/penable      paddr, pwdata, prdata (image_width, image_height)
//
// A byte is loaded into the bit buffer, then the pixel engine emits each pixel it
// completes, one pixel per cycle while out_stall is low and up to eight per byte,
// before it loads the next. A small byte queue keeps accepting while pixels drain.
// Reset clears the queue, bit buffer, counters and output valid; sizes reset to 1.
// in_stall rises only when the queue is full; out_stall holds the output register.
module flagged_rgb_bitstream_unpacker_core #(
    parameter int COORD_BITS  = fbu_pkg::COORD_BITS_DEF,
    parameter int QUEUE_DEPTH = fbu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [fbu_pkg::BYTE_W-1:0]     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fbu_pkg::BYTE_W-1:0]     red,
    output logic [fbu_pkg::BYTE_W-1:0]     green,
    output logic [fbu_pkg::BYTE_W-1:0]     blue,
    output logic                           end_of_row,
    output logic                           last_of_image,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fbu_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fbu_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fbu_pkg::*;

    logic [REG_W-1:0] width_reg, width_next;
    logic [REG_W-1:0] height_reg, height_next;
    logic             wr_en;
    reg_idx_t         reg_idx;
    queue_head_t      head;
    logic             pop;
    pixel_t           pixel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[2]);

    // Decode register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_WIDTH:  width_next  = pwdata[REG_W-1:0];
                REG_HEIGHT: height_next = pwdata[REG_W-1:0];
                default:    width_next  = width_reg;
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= REG_W'(1);
            height_reg <= REG_W'(1);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    fbu_in_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .head      (head),
        .pop       (pop)
    );

    fbu_pixel_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel        (pixel)
    );

    assign red           = pixel.red;
    assign green         = pixel.green;
    assign blue          = pixel.blue;
    assign end_of_row    = pixel.end_of_row;
    assign last_of_image = pixel.last_of_image;

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbu_pkg::*;

    localparam int COORD          = COORD_BITS_DEF;
    localparam int MAX_SIZE       = 1 << COORD;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 1500;
    localparam int PHASE_ITEMS    = 13;
    localparam int NUM_PHASES     = 12;

    // Mirror of the unpacker: sizes, bit buffer, raster position and pending pixels
    class pixel_scoreboard;
        logic [REG_W-1:0] width_reg;
        logic [REG_W-1:0] height_reg;
        logic [BUF_W-1:0] bits;
        int unsigned      held;
        int unsigned      col;
        int unsigned      row;
        pixel_t           pending[$];
        int               errors;
        int               bytes_in;
        int               pixels_out;
        int               fills;
        int               fulls;
        int               rows_done;
        int               images_done;

        function new();
            width_reg   = 1;
            height_reg  = 1;
            bits        = '0;
            held        = 0;
            col         = 0;
            row         = 0;
            errors      = 0;
            bytes_in    = 0;
            pixels_out  = 0;
            fills       = 0;
            fulls       = 0;
            rows_done   = 0;
            images_done = 0;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
            if (idx == REG_WIDTH)
                width_reg = value[REG_W-1:0];
            else
                height_reg = value[REG_W-1:0];
        endfunction

        function int unsigned clamp_size(logic [REG_W-1:0] v);
            if (v == '0)
                return 1;
            if (v > MAX_SIZE)
                return MAX_SIZE;
            return v;
        endfunction

        function logic [BUF_W-1:0] keep_low(int unsigned n);
            if (n >= BUF_W)
                return '1;
            return (BUF_W'(1) << n) - BUF_W'(1);
        endfunction

        // Append the byte to the bit buffer and queue the pixels it completes, at most eight
        function void note_byte(logic [BYTE_W-1:0] b);
            int unsigned w;
            int unsigned h;
            int          n;
            pixel_t      px;
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            n = 0;
            bytes_in++;
            bits = ((bits << 8) | BUF_W'(b)) & keep_low(held + 8);
            held += 8;
            while (held >= 1 && n < 8)
            begin
                if (bits[held-1])
                begin
                    px.red   = 8'hFF;
                    px.green = 8'h00;
                    px.blue  = 8'hFF;
                    held -= 1;
                    fills++;
                end
                else
                begin
                    // hold an incomplete full-color pixel for later bytes
                    if (held < 25)
                        break;
                    px.red   = bits[held-2 -: 8];
                    px.green = bits[held-10 -: 8];
                    px.blue  = bits[held-18 -: 8];
                    held -= 25;
                    fulls++;
                end
                bits &= keep_low(held);
                px.end_of_row    = (col + 1 >= w);
                px.last_of_image = px.end_of_row && (row + 1 >= h);
                pending.push_back(px);
                n++;
                if (px.end_of_row)
                    rows_done++;
                // drop the leftover bits at the end of an image
                if (px.last_of_image)
                begin
                    col  = 0;
                    row  = 0;
                    bits = '0;
                    held = 0;
                    images_done++;
                    break;
                end
                if (px.end_of_row)
                begin
                    col = 0;
                    row = (row + 1) & (MAX_SIZE - 1);
                end
                else
                begin
                    col = (col + 1) & (MAX_SIZE - 1);
                end
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            pixels_out++;
            if (pending.size() == 0)
            begin
                complain($sformatf("pixel %0d unexpected: rgb %02h %02h %02h eor %0b last %0b",
                                   pixels_out, got.red, got.green, got.blue,
                                   got.end_of_row, got.last_of_image));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                complain($sformatf({"pixel %0d exp rgb %02h %02h %02h eor %0b last %0b, ",
                                    "got rgb %02h %02h %02h eor %0b last %0b"},
                                   pixels_out, want.red, want.green, want.blue,
                                   want.end_of_row, want.last_of_image,
                                   got.red, got.green, got.blue,
                                   got.end_of_row, got.last_of_image));
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte     = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [BYTE_W-1:0]     red;
    logic [BYTE_W-1:0]     green;
    logic [BYTE_W-1:0]     blue;
    logic                  end_of_row;
    logic                  last_of_image;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pixel_scoreboard sb;
    int              idle_cycles  = 0;
    int              stall_left   = 0;
    int              free_left    = 0;
    int              settings     = 0;
    bit              burst_mode   = 1'b0;
    bit              stream_bits[$];
    logic [7:0]      byte_pool[$];

    flagged_rgb_bitstream_unpacker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .end_of_row    (end_of_row),
        .last_of_image (last_of_image),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check pixels, note accepted bytes, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_pixel(pixel_t'({red, green, blue, end_of_row, last_of_image}));
            if (in_valid && !in_stall)
                sb.note_byte(data_byte);
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d pixels pending",
                         idle_cycles, sb.pending.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stall the output: mostly short bursts, a few long holds, some free stretches
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 99) < 10)
                free_left = $urandom_range(40, 120);
            else
                free_left = $urandom_range(0, 4);
            if ($urandom_range(0, 99) < 8)
                stall_left = $urandom_range(15, 45);
            else
                stall_left = $urandom_range(1, 3);
        end
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (burst_mode || sel < 45)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_color();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [APB_ADDR_W-1:0] reg_addr(reg_idx_t idx);
        return APB_ADDR_W'(idx) << 2;
    endfunction

    // Offer one item after an optional gap; return at the falling edge after acceptance
    task automatic drive_byte(logic [7:0] b, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Lower valid and wait until every pixel is out and the engine has settled
    task automatic go_idle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write a register, then read it back in a back-to-back transfer
    task automatic write_reg_verify(reg_idx_t idx, logic [REG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word    = ($urandom & ~APB_DATA_W'(13'h1FFF)) | APB_DATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(idx);
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, word);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(value))
            sb.complain($sformatf("register %s readback exp %08h got %08h",
                                  idx.name(), APB_DATA_W'(value), prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_size(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
        write_reg_verify(REG_WIDTH, w);
        write_reg_verify(REG_HEIGHT, h);
        settings++;
    endtask

    // Push bits MSB first and cut whole bytes off the front
    task automatic pack_bits(logic [31:0] v, int n);
        logic [7:0] b;
        for (int i = n - 1; i >= 0; i--)
            stream_bits.push_back(v[i]);
        while (stream_bits.size() >= 8)
        begin
            for (int k = 0; k < 8; k++)
                b = {b[6:0], stream_bits.pop_front()};
            byte_pool.push_back(b);
        end
    endtask

    // Mostly well-formed pixels with random colors, a little raw noise
    task automatic build_stream(int count);
        int sel;
        byte_pool.delete();
        while (byte_pool.size() < count)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       byte_pool.push_back(8'hFF);
                    1:       byte_pool.push_back(8'h00);
                    default: byte_pool.push_back(8'($urandom));
                endcase
            end
            else if (sel < 5)
            begin
                pack_bits(32'd1, 1);
            end
            else
            begin
                pack_bits({7'd0, 1'b0, pick_color(), pick_color(), pick_color()}, 25);
            end
        end
    endtask

    task automatic run_phase(int count, bit pause_midway);
        build_stream(count);
        for (int i = 0; i < count; i++)
        begin
            // hold the sender until the pipeline has fully drained
            if (pause_midway && i == count / 2)
            begin
                in_valid <= 1'b0;
                while (sb.pending.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            drive_byte(byte_pool[i], pick_gap());
        end
        go_idle();
    endtask

    int unsigned phase_w[NUM_PHASES] = '{1, 2, 3, 4096, 4097, 1, 5, 0, 8191, 2, 7, 4};
    int unsigned phase_h[NUM_PHASES] = '{1, 3, 1, 1, 2, 4096, 2, 3, 0, 2, 8191, 4};

    initial
    begin
        sb = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset sizes of one by one: fill, fill with dropped tail, all-zero and all-one pixels
        drive_byte(8'hFF, 0);
        drive_byte(8'h80, pick_gap());
        drive_byte(8'h00, 0);
        drive_byte(8'h00, 0);
        drive_byte(8'h00, 0);
        drive_byte(8'h00, pick_gap());
        drive_byte(8'h7F, 0);
        drive_byte(8'hFF, 0);
        drive_byte(8'hFF, 0);
        drive_byte(8'hFF, 0);
        go_idle();

        // Small image: one item of fills completes all six pixels, rows of three, tail dropped
        set_size(3, 2);
        drive_byte(8'hFF, 0);
        drive_byte(8'h40, 0);
        drive_byte(8'h12, 0);
        drive_byte(8'h34, 0);
        drive_byte(8'h56, pick_gap());
        drive_byte(8'hFF, 0);
        go_idle();

        // Zero sizes act as one
        set_size(0, 0);
        drive_byte(8'hFF, 0);
        drive_byte(8'h01, 0);
        go_idle();

        // Largest sizes, then shrink mid-image so the counters are already past the end
        set_size(13'h1FFF, 13'h1FFF);
        drive_byte(8'hFF, 0);
        drive_byte(8'hFF, 0);
        drive_byte(8'hFF, 0);
        go_idle();
        set_size(2, 1);
        drive_byte(8'hFF, 0);
        go_idle();

        // Random phases over a spread of sizes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_size(REG_W'(phase_w[p]), REG_W'(phase_h[p]));
            burst_mode = (p == 2 || p == 7);
            run_phase(PHASE_ITEMS, p == 4);
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d bytes, %0d pixels (%0d fill, %0d full color), %0d size settings",
                 sb.bytes_in, sb.pixels_out, sb.fills, sb.fulls, settings);
        $display("rows ended %0d, images completed %0d, mismatches %0d, pixels left over %0d",
                 sb.rows_done, sb.images_done, sb.errors, sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
